/* hw/rtl/sida_pkg.sv */
package sida_pkg;

    localparam int VALUE_W  = 32;
    localparam int CHAR_W   = 8;
    localparam int DIGIT_W  = 4;
    localparam int POS_W    = 4;
    localparam int BSEL_W   = 2;
    localparam int WEIGHT_W = 34;   // 8 * 10^9 needs 33 bits, one spare

    localparam logic [POS_W-1:0]  POS_TOP  = 4'd9;
    localparam logic [BSEL_W-1:0] BSEL_TOP = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_STEP,
        ST_EMIT
    } state_t;

    // Sequencer to datapath and output stage
    typedef struct packed {
        logic              load;
        logic              step;
        logic              clr_digit;
        logic              push;
        logic              push_sign;
        logic              push_last;
        logic [POS_W-1:0]  pos;
        logic [BSEL_W-1:0] bsel;
    } ctrl_t;

    // Trial weight: 10^pos * 2^bsel
    function automatic logic [WEIGHT_W-1:0] weight_of(
        input logic [POS_W-1:0]  pos,
        input logic [BSEL_W-1:0] bsel
    );
        logic [WEIGHT_W-1:0] p;
        unique case (pos)
            4'd0:    p = 34'd1;
            4'd1:    p = 34'd10;
            4'd2:    p = 34'd100;
            4'd3:    p = 34'd1000;
            4'd4:    p = 34'd10000;
            4'd5:    p = 34'd100000;
            4'd6:    p = 34'd1000000;
            4'd7:    p = 34'd10000000;
            4'd8:    p = 34'd100000000;
            4'd9:    p = 34'd1000000000;
            default: p = 34'd0;
        endcase
        return p << bsel;
    endfunction

endpackage

/* hw/rtl/sida_datapath.sv */
module sida_datapath
    import sida_pkg::*;
(
    input  logic                      aclk,
    input  logic [VALUE_W-1:0]        s_value,
    input  ctrl_t                     ctrl,
    output logic [DIGIT_W-1:0]        digit,
    output logic                      neg
);

    logic [VALUE_W-1:0]  mag_reg, mag_next;
    logic [DIGIT_W-1:0]  digit_reg, digit_next;
    logic                neg_reg, neg_next;
    logic [WEIGHT_W:0]   diff;
    logic                fits;

    // shared compare-subtract unit
    assign diff = {{(WEIGHT_W + 1 - VALUE_W){1'b0}}, mag_reg}
                - {1'b0, weight_of(ctrl.pos, ctrl.bsel)};
    assign fits = ~diff[WEIGHT_W];

    always_comb begin
        mag_next   = mag_reg;
        digit_next = digit_reg;
        neg_next   = neg_reg;
        if (ctrl.load) begin
            neg_next   = s_value[VALUE_W-1];
            mag_next   = s_value[VALUE_W-1] ? (VALUE_W'(0) - s_value) : s_value;
            digit_next = '0;
        end else if (ctrl.step) begin
            if (fits) begin
                mag_next              = diff[VALUE_W-1:0];
                digit_next[ctrl.bsel] = 1'b1;
            end
        end else if (ctrl.clr_digit) begin
            digit_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg   <= mag_next;
        digit_reg <= digit_next;
        neg_reg   <= neg_next;
    end

    assign digit = digit_reg;
    assign neg   = neg_reg;

endmodule

/* hw/rtl/sida_ctrl.sv */
module sida_ctrl
    import sida_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               slot_free,
    input  logic               neg,
    input  logic [DIGIT_W-1:0] digit,
    output ctrl_t              ctrl
);

    state_t            state_reg, state_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BSEL_W-1:0] bsel_reg, bsel_next;
    logic              started_reg, started_next;
    logic              show;
    logic              advance;

    // digit is printed unless it is a leading zero
    assign show    = (digit != '0) || started_reg || (pos_reg == '0);
    assign advance = !show || slot_free;

    // next state
    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        bsel_next    = bsel_reg;
        started_next = started_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    pos_next     = POS_TOP;
                    bsel_next    = BSEL_TOP;
                    started_next = 1'b0;
                    state_next   = ST_SIGN;
                end
            end
            ST_SIGN: begin
                if (!neg) begin
                    state_next = ST_STEP;
                end else if (slot_free) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                bsel_next = bsel_reg - BSEL_W'(1);
                if (bsel_reg == '0) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (advance) begin
                    started_next = started_reg | show;
                    bsel_next    = BSEL_TOP;
                    if (pos_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        pos_next   = pos_reg - POS_W'(1);
                        state_next = ST_STEP;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready        = 1'b0;
        ctrl           = '0;
        ctrl.pos       = pos_reg;
        ctrl.bsel      = bsel_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                ctrl.load = s_valid;
            end
            ST_SIGN: begin
                ctrl.push      = neg && slot_free;
                ctrl.push_sign = 1'b1;
            end
            ST_STEP: begin
                ctrl.step = 1'b1;
            end
            ST_EMIT: begin
                ctrl.push      = show && slot_free;
                ctrl.push_last = (pos_reg == '0);
                ctrl.clr_digit = advance;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= POS_TOP;
            bsel_reg    <= BSEL_TOP;
            started_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            bsel_reg    <= bsel_next;
            started_reg <= started_next;
        end
    end

endmodule

/* hw/rtl/signed_int_to_decimal_ascii.sv */
// Signed 32-bit integer to decimal ASCII. Each accepted item on s_value
// produces its decimal text on the m_ channel, one character per item,
// most significant digit first, no leading zeros, a leading '-' for
// negative values, and m_last high on the final character. Zero gives a
// single '0'; -2147483648 gives eleven characters. The block holds one
// number at a time and s_ready is low while it converts. Digits come from
// a single compare-subtract unit that tries 8, 4, 2 and 1 times the
// current power of ten, one trial per cycle: every decimal place from
// 10^9 down to 10^0 gets these trials and then an emit step, leading
// zeros included. An item passes accept, the sign slot and the ten
// places before s_ready is high again; m_ready can hold back a pending
// character at the sign slot or an emit step. A one-entry output
// register parts the two sides, so the next number can be accepted while
// the final character is still waiting to be taken. Nothing is kept from
// one number to the next.
module signed_int_to_decimal_ascii
    import sida_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [VALUE_W-1:0]  s_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CHAR_W-1:0]   m_character,
    output logic                m_last
);

    ctrl_t               ctrl;
    logic [DIGIT_W-1:0]  digit;
    logic                neg;
    logic                slot_free;

    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   out_char_reg, out_char_next;
    logic                out_last_reg, out_last_next;

    // output slot can take a character if empty or being drained this cycle
    assign slot_free = !out_valid_reg || m_ready;

    sida_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .slot_free (slot_free),
        .neg       (neg),
        .digit     (digit),
        .ctrl      (ctrl)
    );

    sida_datapath u_datapath (
        .aclk    (aclk),
        .s_value (s_value),
        .ctrl    (ctrl),
        .digit   (digit),
        .neg     (neg)
    );

    // output register: sign or digit character with its last flag
    always_comb begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (ctrl.push) begin
            out_valid_next = 1'b1;
            out_char_next  = ctrl.push_sign ? CHAR_MINUS
                                            : (CHAR_ZERO + {{(CHAR_W - DIGIT_W){1'b0}}, digit});
            out_last_next  = ctrl.push_last;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_character = out_char_reg;
    assign m_last      = out_last_reg;

`ifndef SYNTHESIS
    // a character is only pushed into a free output slot
    a_push_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.push |-> slot_free)
        else $error("character pushed into occupied output slot");

    // finished digit never exceeds nine
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.push && !ctrl.push_sign) |-> (digit <= DIGIT_MAX))
        else $error("decimal digit out of range");

    // only '-' or '0'..'9' leave the block
    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_character == CHAR_MINUS) ||
                     ((m_character >= CHAR_ZERO) &&
                      (m_character <= (CHAR_ZERO + {{(CHAR_W - DIGIT_W){1'b0}}, DIGIT_MAX})))))
        else $error("output character outside digit and sign set");

    // a sign is always followed by at least one digit
    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_character == CHAR_MINUS)) |-> !m_last)
        else $error("sign flagged as last character");

    // no new number while the converter is busy
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.step || ctrl.push_sign) |-> !s_ready)
        else $error("input ready during conversion");
`endif

endmodule
